// ----- rtl/msic_pkg.sv -----
// package: types, opcodes and constants shared by the instruction core
package msic_pkg;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_TRAP    = 6'h1a;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SW      = 6'h2b;

  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRA  = 6'h03;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_MFHI = 6'h10;
  localparam logic [5:0] FN_MFLO = 6'h12;
  localparam logic [5:0] FN_MULT = 6'h18;
  localparam logic [5:0] FN_DIV  = 6'h1a;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_SLT  = 6'h2a;

  localparam logic [3:0] TRAP_NEWLINE = 4'h0;
  localparam logic [3:0] TRAP_PRINT   = 4'h1;
  localparam logic [3:0] TRAP_READ    = 4'h5;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_NEWLINE = 2'd1;
  localparam logic [1:0] KIND_PRINT   = 2'd2;
  localparam logic [1:0] KIND_READ    = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_UNIMPL = 2'd1;
  localparam logic [1:0] ST_MFAULT = 2'd2;
  localparam logic [1:0] ST_DIVZ   = 2'd3;

  localparam logic [31:0] DMEM_BASE = 32'h1000_0000;
  localparam logic [31:0] GP_INIT   = 32'h1000_8000;
  localparam logic [4:0]  REG_GP    = 5'd28;
  localparam logic [4:0]  REG_SP    = 5'd29;
  localparam logic [4:0]  REG_RA    = 5'd31;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RDA, S_RDB, S_EXEC, S_MUL, S_DIV, S_MEM, S_WB, S_OUT
  } state_t;

  // divider request and result
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
    logic [31:0] rem;
  } div_rsp_t;

endpackage

// ----- rtl/msic_if.sv -----
// valid/ready channel interfaces for instruction input, result output and config
interface msic_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;
  logic signed [31:0] console_value;
  modport source (output valid, instr_word, console_value, input ready);
  modport sink (input valid, instr_word, console_value, output ready);
endinterface

interface msic_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic [1:0]  print_kind;
  logic signed [31:0] print_value;
  logic        halted;
  logic [1:0]  status;
  modport source (output valid, next_pc, print_kind, print_value, halted, status,
                  input ready);
  modport sink (input valid, next_pc, print_kind, print_value, halted, status,
                output ready);
endinterface

interface msic_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] reset_pc;
  modport source (output valid, reset_pc, input ready);
  modport sink (input valid, reset_pc, output ready);
endinterface

// ----- rtl/msic_div.sv -----
// signed 32-bit radix-2 restoring divider, one quotient bit per cycle
module msic_div (
  input  logic              clk,
  input  logic              rst,
  input  msic_pkg::div_req_t req,
  output msic_pkg::div_rsp_t rsp
);
  import msic_pkg::*;

  logic [31:0] quo;
  logic [32:0] rem;
  logic [31:0] den;
  logic [5:0]  cnt;
  logic        busy;
  logic        neg_q;
  logic        neg_r;
  logic        done;
  logic [32:0] trial;
  logic [32:0] shifted;

  // shift in next dividend bit and try subtract
  always_comb begin
    shifted = {rem[31:0], quo[31]};
    trial   = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        cnt   <= 6'd32;
        neg_q <= req.num[31] ^ req.den[31];
        neg_r <= req.num[31];
        quo   <= req.num[31] ? (~req.num + 32'd1) : req.num;
        den   <= req.den[31] ? (~req.den + 32'd1) : req.den;
        rem   <= '0;
      end else if (busy) begin
        if (trial[32]) begin
          rem <= shifted;
          quo <= {quo[30:0], 1'b0};
        end else begin
          rem <= trial;
          quo <= {quo[30:0], 1'b1};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // sign fixup on result
  always_comb begin
    rsp.done = done;
    rsp.quo  = neg_q ? (~quo + 32'd1) : quo;
    rsp.rem  = neg_r ? (~rem[31:0] + 32'd1) : rem[31:0];
  end

  assert property (@(posedge clk) disable iff (rst) req.start |=> busy);
  assert property (@(posedge clk) disable iff (rst) done |-> !busy);
  assert property (@(posedge clk) disable iff (rst) busy |-> cnt != 6'd0);
endmodule

// ----- rtl/msic_regfile.sv -----
// 32 x 32 register file in a synchronous memory, one read and one write port; preset by the core after reset
module msic_regfile (
  input  logic        clk,
  input  logic [4:0]  raddr,
  output logic [31:0] rdata,
  input  logic        we,
  input  logic [4:0]  waddr,
  input  logic [31:0] wdata
);
  import msic_pkg::*;

  logic [31:0] mem [32];

  // registered read, single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/msic_dmem.sv -----
// word data memory, synchronous registered read
module msic_dmem #(
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  output logic [31:0]              rdata,
  input  logic                     we,
  input  logic [31:0]              wdata
);
  import msic_pkg::*;

  logic [31:0] mem [DEPTH];

  // read-before-write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- rtl/mips_subset_instruction_core_unit.sv -----
// top level: multi-cycle subset instruction core with register file and data memory
// one instruction in flight; the next is taken in the cycle after the result
// transaction. the sequencer reads rs then rt from the register file memory,
// which has a single read port. after reset a clearing pass zeroes the data
// memory and presets the register file; no instruction is taken until then.
module mips_subset_instruction_core_unit #(
  parameter int DMEM_WORDS = 4096
) (
  input  logic clk,
  input  logic rst,
  msic_in_if.sink    in_ch,
  msic_out_if.source out_ch,
  msic_cfg_if.sink   cfg
);
  import msic_pkg::*;

  localparam int AW = $clog2(DMEM_WORDS);
  localparam int CW = (AW > 5) ? AW : 5;
  localparam int CLR_LAST = ((DMEM_WORDS > 32) ? DMEM_WORDS : 32) - 1;
  localparam logic [31:0] SP_INIT = DMEM_BASE + 32'(4 * DMEM_WORDS);

  state_t state, state_next;

  logic [31:0] pc;
  logic [31:0] hi, lo;
  logic        stopped;
  logic [CW:0] clr_cnt;
  logic [31:0] iw, cval, a, b;
  logic [31:0] npc;
  logic [1:0]  kind, st;
  logic [31:0] pval;
  logic        wr_en;
  logic [4:0]  wr_dst;
  logic [31:0] wr_val;
  logic        is_load;
  logic        mem_st;
  logic [AW-1:0] mem_idx;
  logic signed [63:0] prod;

  // decode fields
  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sh;
  logic [31:0] uimm, simm, maddr, moff;
  logic [31:0] pc4;
  assign op   = iw[31:26];
  assign rs   = iw[25:21];
  assign rt   = iw[20:16];
  assign rd   = iw[15:11];
  assign sh   = iw[10:6];
  assign fn   = iw[5:0];
  assign uimm = {16'd0, iw[15:0]};
  assign simm = {{16{iw[15]}}, iw[15:0]};
  assign maddr = a + simm;
  assign moff  = maddr - DMEM_BASE;
  assign pc4   = pc + 32'd4;

  logic        moff_ok;
  always_comb begin
    moff_ok = (moff[1:0] == 2'b00) && ({2'b00, moff[31:2]} < 32'(DMEM_WORDS));
  end

  // register file ports
  logic [4:0]  rf_raddr, rf_waddr;
  logic [31:0] rf_rdata, rf_wdata;
  logic        rf_we;
  msic_regfile u_rf (
    .clk(clk), .raddr(rf_raddr), .rdata(rf_rdata),
    .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata)
  );

  // data memory ports
  logic [AW-1:0] dm_addr;
  logic [31:0]   dm_rdata, dm_wdata;
  logic          dm_we;
  msic_dmem #(.DEPTH(DMEM_WORDS)) u_dm (
    .clk(clk), .addr(dm_addr), .rdata(dm_rdata), .we(dm_we), .wdata(dm_wdata)
  );

  div_req_t dreq;
  div_rsp_t drsp;
  msic_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_cnt == (CW+1)'(CLR_LAST)) state_next = S_IDLE;
      S_IDLE:  if (in_ch.valid) state_next = stopped ? S_OUT : S_RDA;
      S_RDA:   state_next = S_RDB;
      S_RDB:   state_next = S_EXEC;
      S_EXEC: begin
        if (op == OP_SPECIAL && fn == FN_MULT) state_next = S_MUL;
        else if (op == OP_SPECIAL && fn == FN_DIV && b != 32'd0) state_next = S_DIV;
        else if ((op == OP_LW || op == OP_SW) && moff_ok) state_next = S_MEM;
        else state_next = S_WB;
      end
      S_MUL:   state_next = S_WB;
      S_DIV:   if (drsp.done) state_next = S_WB;
      S_MEM:   state_next = S_WB;
      S_WB:    state_next = S_OUT;
      S_OUT:   if (out_ch.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory, divider and handshake outputs
  always_comb begin
    in_ch.ready  = (state == S_IDLE);
    out_ch.valid = (state == S_OUT);
    // config accepted while clearing, or while idle and no instruction is offered
    cfg.ready    = ((state == S_IDLE) && !in_ch.valid) || (state == S_CLEAR);
    rf_raddr = rs;
    rf_we    = 1'b0;
    rf_waddr = wr_dst;
    rf_wdata = wr_val;
    dm_addr  = mem_idx;
    dm_we    = 1'b0;
    dm_wdata = b;
    dreq.start = (state == S_EXEC) && (state_next == S_DIV);
    dreq.num   = a;
    dreq.den   = b;
    case (state)
      S_CLEAR: begin
        dm_addr  = clr_cnt[AW-1:0];
        dm_we    = 1'b1;
        dm_wdata = '0;
        if (clr_cnt < (CW+1)'(32)) begin
          rf_we    = 1'b1;
          rf_waddr = clr_cnt[4:0];
          rf_wdata = (clr_cnt[4:0] == REG_GP) ? GP_INIT :
                     (clr_cnt[4:0] == REG_SP) ? SP_INIT : 32'd0;
        end
      end
      S_IDLE:  rf_raddr = in_ch.instr_word[25:21];
      S_RDA:   rf_raddr = rt;
      S_MEM:   dm_we = mem_st;
      S_WB: begin
        rf_we = wr_en && (wr_dst != 5'd0);
        // load data read during the memory state is valid here
        if (is_load) rf_wdata = dm_rdata;
      end
      default: ;
    endcase
  end

  // execute, capture and bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      pc      <= '0;
      hi      <= '0;
      lo      <= '0;
      stopped <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (cfg.valid && cfg.ready) pc <= cfg.reset_pc;
      case (state)
        S_IDLE: begin
          iw   <= in_ch.instr_word;
          cval <= in_ch.console_value;
          npc  <= pc;
          kind <= KIND_NONE;
          pval <= '0;
          st   <= ST_OK;
          wr_en <= 1'b0;
          is_load <= 1'b0;
          mem_st  <= 1'b0;
        end
        S_RDA: a <= rf_rdata;
        S_RDB: b <= rf_rdata;
        S_EXEC: begin
          npc    <= pc + 32'd4;
          wr_en  <= 1'b0;
          wr_dst <= rd;
          wr_val <= '0;
          mem_idx <= moff[AW+1:2];
          case (op)
            OP_SPECIAL: begin
              case (fn)
                FN_SLL:  begin wr_en <= 1'b1; wr_val <= b << sh; end
                FN_SRA:  begin wr_en <= 1'b1; wr_val <= $signed(b) >>> sh; end
                FN_JR:   npc <= a;
                FN_MFHI: begin wr_en <= 1'b1; wr_val <= hi; end
                FN_MFLO: begin wr_en <= 1'b1; wr_val <= lo; end
                FN_MULT: prod <= $signed(a) * $signed(b);
                FN_DIV:  if (b == 32'd0) st <= ST_DIVZ;
                FN_ADDU: begin wr_en <= 1'b1; wr_val <= a + b; end
                FN_SUBU: begin wr_en <= 1'b1; wr_val <= a - b; end
                FN_SLT:  begin wr_en <= 1'b1; wr_val <= {31'd0, $signed(a) < $signed(b)}; end
                default: st <= ST_UNIMPL;
              endcase
            end
            // jump region comes from the incremented pc
            OP_J:  npc <= {pc4[31:28], iw[25:0], 2'b00};
            OP_JAL: begin
              wr_en <= 1'b1; wr_dst <= REG_RA; wr_val <= pc + 32'd4;
              npc <= {pc4[31:28], iw[25:0], 2'b00};
            end
            OP_BEQ: if (a == b) npc <= pc + 32'd4 + {simm[29:0], 2'b00};
            OP_BNE: if (a != b) npc <= pc + 32'd4 + {simm[29:0], 2'b00};
            OP_ADDIU: begin wr_en <= 1'b1; wr_dst <= rt; wr_val <= a + simm; end
            OP_ANDI:  begin wr_en <= 1'b1; wr_dst <= rt; wr_val <= a & uimm; end
            OP_LUI:   begin wr_en <= 1'b1; wr_dst <= rt; wr_val <= {iw[15:0], 16'd0}; end
            OP_TRAP: begin
              case (iw[3:0])
                TRAP_NEWLINE: kind <= KIND_NEWLINE;
                TRAP_PRINT:   begin kind <= KIND_PRINT; pval <= a; end
                TRAP_READ: begin
                  kind <= KIND_READ; wr_en <= 1'b1; wr_dst <= rt; wr_val <= cval;
                end
                default: stopped <= 1'b1;
              endcase
            end
            OP_LW: begin
              wr_dst <= rt;
              if (moff_ok) is_load <= 1'b1; else st <= ST_MFAULT;
            end
            OP_SW: if (moff_ok) mem_st <= 1'b1; else st <= ST_MFAULT;
            default: st <= ST_UNIMPL;
          endcase
        end
        S_MUL: begin
          lo <= prod[31:0];
          hi <= prod[63:32];
        end
        S_DIV: if (drsp.done) begin
          lo <= drsp.quo;
          hi <= drsp.rem;
        end
        S_MEM: if (is_load) begin
          wr_en  <= 1'b1;
        end
        S_WB: begin
          pc <= npc;
        end
        default: ;
      endcase
    end
  end

  // result payload
  always_comb begin
    out_ch.next_pc     = npc;
    out_ch.print_kind  = kind;
    out_ch.print_value = pval;
    out_ch.halted      = stopped;
    out_ch.status      = st;
  end

  assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |-> !out_ch.valid);
  assert property (@(posedge clk) disable iff (rst)
    state == S_WB && st != ST_OK |-> !rf_we || kind == KIND_READ);
  assert property (@(posedge clk) disable iff (rst)
    rf_we && state != S_CLEAR |-> rf_waddr != 5'd0);
  assert property (@(posedge clk) disable iff (rst)
    dm_we && state != S_CLEAR |-> state == S_MEM && mem_st);
endmodule

// ----- sim/testbench.sv -----
// testbench for the subset instruction core: directed and random programs checked against a predictor
module testbench;
  import msic_pkg::*;

  localparam int MEM_WORDS   = 4096;
  localparam int CYCLE_LIMIT = 900000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  msic_in_if  in_ch ();
  msic_out_if out_ch ();
  msic_cfg_if cfg ();

  mips_subset_instruction_core_unit #(.DMEM_WORDS(MEM_WORDS)) dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg(cfg.sink)
  );

  typedef struct packed {
    logic [31:0] next_pc;
    logic [1:0]  print_kind;
    logic [31:0] print_value;
    logic        halted;
    logic [1:0]  status;
  } core_result_t;

  // predictor state
  logic [31:0] model_pc;
  logic [31:0] model_regs [32];
  logic [31:0] model_hi, model_lo;
  logic [31:0] model_mem [MEM_WORDS];
  logic        model_stopped;

  core_result_t expected_results [$];
  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cycle counter and run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("mips_subset_instruction_core_unit test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  function automatic void reset_core_model();
    model_pc = 32'h0;
    foreach (model_regs[i]) model_regs[i] = 32'h0;
    model_regs[REG_GP] = GP_INIT;
    model_regs[REG_SP] = DMEM_BASE + 4 * MEM_WORDS;
    model_hi = 32'h0;
    model_lo = 32'h0;
    foreach (model_mem[i]) model_mem[i] = 32'h0;
    model_stopped = 1'b0;
  endfunction

  function automatic void write_reg(input logic [4:0] r, input logic [31:0] v);
    if (r != 5'd0) model_regs[r] = v;
  endfunction

  // execute one instruction in the predictor
  function automatic core_result_t execute_instr(input logic [31:0] iw,
                                                 input logic [31:0] cval);
    core_result_t res;
    logic [31:0] npc, a, b, simm, addr, off;
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh;
    logic signed [63:0] prod;
    longint sa, sb;
    res = '0;
    if (model_stopped) begin
      res.next_pc = model_pc;
      res.halted = 1'b1;
      return res;
    end
    npc = model_pc + 4;
    op = iw[31:26]; rs = iw[25:21]; rt = iw[20:16]; rd = iw[15:11];
    sh = iw[10:6];  fn = iw[5:0];
    simm = {{16{iw[15]}}, iw[15:0]};
    a = model_regs[rs];
    b = model_regs[rt];
    sa = $signed(a);
    sb = $signed(b);
    res.status = ST_OK;
    res.print_kind = KIND_NONE;
    case (op)
      OP_SPECIAL: begin
        case (fn)
          FN_SLL:  write_reg(rd, b << sh);
          FN_SRA:  write_reg(rd, $unsigned($signed(b) >>> sh));
          FN_JR:   npc = a;
          FN_MFHI: write_reg(rd, model_hi);
          FN_MFLO: write_reg(rd, model_lo);
          FN_MULT: begin
            prod = sa * sb;
            model_lo = prod[31:0];
            model_hi = prod[63:32];
          end
          FN_DIV: begin
            if (b == 32'h0) res.status = ST_DIVZ;
            else begin
              model_lo = 32'(sa / sb);
              model_hi = 32'(sa % sb);
            end
          end
          FN_ADDU: write_reg(rd, a + b);
          FN_SUBU: write_reg(rd, a - b);
          FN_SLT:  write_reg(rd, {31'h0, $signed(a) < $signed(b)});
          default: res.status = ST_UNIMPL;
        endcase
      end
      OP_J:   npc = {npc[31:28], iw[25:0], 2'b00};
      OP_JAL: begin
        write_reg(REG_RA, npc);
        npc = {npc[31:28], iw[25:0], 2'b00};
      end
      OP_BEQ: if (a == b) npc = npc + (simm << 2);
      OP_BNE: if (a != b) npc = npc + (simm << 2);
      OP_ADDIU: write_reg(rt, a + simm);
      OP_ANDI:  write_reg(rt, a & {16'h0, iw[15:0]});
      OP_LUI:   write_reg(rt, {iw[15:0], 16'h0});
      OP_TRAP: begin
        case (iw[3:0])
          TRAP_NEWLINE: res.print_kind = KIND_NEWLINE;
          TRAP_PRINT: begin
            res.print_kind = KIND_PRINT;
            res.print_value = a;
          end
          TRAP_READ: begin
            res.print_kind = KIND_READ;
            write_reg(rt, cval);
          end
          default: model_stopped = 1'b1;
        endcase
      end
      OP_LW, OP_SW: begin
        addr = a + simm;
        off = addr - DMEM_BASE;
        if (off[1:0] != 2'b00 || (off >> 2) >= MEM_WORDS) res.status = ST_MFAULT;
        else if (op == OP_LW) write_reg(rt, model_mem[off >> 2]);
        else model_mem[off >> 2] = b;
      end
      default: res.status = ST_UNIMPL;
    endcase
    model_pc = npc;
    res.next_pc = npc;
    res.halted = model_stopped;
    return res;
  endfunction

  // send one instruction, predicting its result on acceptance
  task automatic send_instr(input logic [31:0] iw, input logic [31:0] cval);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.instr_word <= iw;
    in_ch.console_value <= cval;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_results.push_back(execute_instr(iw, cval));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_start_pc(input logic [31:0] value);
    cfg.valid <= 1'b1;
    cfg.reset_pc <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    model_pc = value;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // receiver ready with random stalls and optional long hold-off
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    core_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("unexpected result transaction at cycle %0d", cycle_count);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_ch.next_pc !== want.next_pc)
          report_mismatch("next_pc", out_ch.next_pc, want.next_pc);
        if (out_ch.print_kind !== want.print_kind)
          report_mismatch("print_kind", 32'(out_ch.print_kind), 32'(want.print_kind));
        if (out_ch.print_value !== want.print_value)
          report_mismatch("print_value", out_ch.print_value, want.print_value);
        if (out_ch.halted !== want.halted)
          report_mismatch("halted", 32'(out_ch.halted), 32'(want.halted));
        if (out_ch.status !== want.status)
          report_mismatch("status", 32'(out_ch.status), 32'(want.status));
      end
    end
  end

  // instruction encoders
  function automatic logic [31:0] r_type(input logic [4:0] rs, rt, rd, sh,
                                         input logic [5:0] fn);
    return {OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] i_type(input logic [5:0] op, input logic [4:0] rs, rt,
                                         input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] trap_instr(input logic [4:0] rs, rt, input logic [3:0] svc);
    return {OP_TRAP, rs, rt, 12'h0, svc};
  endfunction

  function automatic logic [4:0] rand_reg();
    return 5'($urandom_range(31));
  endfunction

  // build a random, mostly valid instruction
  function automatic logic [31:0] random_instr();
    logic [4:0] rs, rt, rd;
    logic [5:0] fns [10];
    int pick;
    fns = '{FN_SLL, FN_SRA, FN_JR, FN_MFHI, FN_MFLO, FN_MULT, FN_DIV, FN_ADDU, FN_SUBU,
            FN_SLT};
    rs = rand_reg(); rt = rand_reg(); rd = rand_reg();
    pick = $urandom_range(99);
    if (pick < 35) begin
      if (fns[pick % 10] == FN_JR) return r_type(rs, rt, rd, 5'($urandom), FN_ADDU);
      return r_type(rs, rt, rd, 5'($urandom), fns[pick % 10]);
    end
    if (pick < 50) return i_type(OP_ADDIU, rs, rt, 16'($urandom));
    if (pick < 55) return i_type(OP_ANDI, rs, rt, 16'($urandom));
    if (pick < 62) return i_type(OP_LUI, rs, rt, 16'($urandom));
    // memory ops based at gp so that some land inside the data memory
    if (pick < 72) return i_type(OP_LW, REG_GP, rt, 16'($urandom_range(65535)) & 16'hfffc);
    if (pick < 82) return i_type(OP_SW, REG_GP, rt, 16'($urandom_range(65535)) & 16'hfffc);
    if (pick < 85) return i_type(OP_LW, rs, rt, 16'($urandom));
    if (pick < 88) return i_type(OP_BEQ, rs, rt, 16'($urandom));
    if (pick < 91) return i_type(OP_BNE, rs, rt, 16'($urandom));
    if (pick < 93) return {OP_JAL, 26'($urandom)};
    if (pick < 95) return {OP_J, 26'($urandom)};
    if (pick < 98) return trap_instr(rs, rt, ($urandom_range(1)) ? TRAP_PRINT : TRAP_READ);
    return $urandom;
  endfunction

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) send_instr(random_instr(), $urandom);
  endtask

  // directed: extremes, every operation and the special cases
  task automatic test_directed();
    send_instr(i_type(OP_LUI, 5'd0, 5'd1, 16'h8000), 32'h0);
    send_instr(i_type(OP_ADDIU, 5'd0, 5'd2, 16'hffff), 32'h0);
    send_instr(i_type(OP_ADDIU, 5'd0, 5'd0, 16'h1234), 32'h0);
    send_instr(r_type(5'd0, 5'd1, 5'd3, 5'd31, FN_SRA), 32'h0);
    send_instr(r_type(5'd0, 5'd2, 5'd4, 5'd31, FN_SLL), 32'h0);
    send_instr(r_type(5'd0, 5'd1, 5'd5, 5'd0, FN_SRA), 32'h0);
    send_instr(r_type(5'd1, 5'd2, 5'd6, 5'd0, FN_SLT), 32'h0);
    send_instr(r_type(5'd1, 5'd2, 5'd7, 5'd0, FN_ADDU), 32'h0);
    send_instr(r_type(5'd1, 5'd2, 5'd8, 5'd0, FN_SUBU), 32'h0);
    send_instr(r_type(5'd1, 5'd2, 5'd0, 5'd0, FN_DIV), 32'h0);
    send_instr(r_type(5'd1, 5'd0, 5'd0, 5'd0, FN_DIV), 32'h0);
    send_instr(r_type(5'd1, 5'd1, 5'd0, 5'd0, FN_MULT), 32'h0);
    send_instr(r_type(5'd0, 5'd0, 5'd9, 5'd0, FN_MFHI), 32'h0);
    send_instr(r_type(5'd0, 5'd0, 5'd10, 5'd0, FN_MFLO), 32'h0);
    send_instr(i_type(OP_ANDI, 5'd2, 5'd11, 16'hffff), 32'h0);
    send_instr(i_type(OP_SW, REG_GP, 5'd2, 16'h7ffc), 32'h0);
    send_instr(i_type(OP_LW, REG_GP, 5'd12, 16'h7ffc), 32'h0);
    send_instr(i_type(OP_LW, REG_GP, 5'd12, 16'h8002), 32'h0);
    send_instr(i_type(OP_SW, REG_SP, 5'd2, 16'h0000), 32'h0);
    send_instr(trap_instr(5'd0, 5'd13, TRAP_READ), 32'h8000_0000);
    send_instr(trap_instr(5'd13, 5'd0, TRAP_PRINT), 32'hffff_ffff);
    send_instr(trap_instr(5'd0, 5'd0, TRAP_NEWLINE), 32'h0);
    send_instr(i_type(OP_BEQ, 5'd0, 5'd0, 16'h8000), 32'h0);
    send_instr(i_type(OP_BNE, 5'd1, 5'd0, 16'h7fff), 32'h0);
    send_instr({OP_JAL, 26'h3ff_ffff}, 32'h0);
    send_instr(r_type(5'd31, 5'd0, 5'd0, 5'd0, FN_JR), 32'h0);
    send_instr(r_type(5'd0, 5'd0, 5'd0, 5'd0, 6'h3f), 32'h0);
    send_instr({6'h3f, 26'h0}, 32'h0);
    send_instr({OP_J, 26'h0}, 32'h0);
  endtask

  // divide overflow case
  task automatic test_divide_overflow();
    send_instr(i_type(OP_LUI, 5'd0, 5'd14, 16'h8000), 32'h0);
    send_instr(i_type(OP_ADDIU, 5'd0, 5'd15, 16'hffff), 32'h0);
    send_instr(r_type(5'd14, 5'd15, 5'd0, 5'd0, FN_DIV), 32'h0);
    send_instr(r_type(5'd0, 5'd0, 5'd16, 5'd0, FN_MFHI), 32'h0);
    send_instr(r_type(5'd0, 5'd0, 5'd17, 5'd0, FN_MFLO), 32'h0);
  endtask

  // halt and unknown-trap halting; later instructions are no-ops
  task automatic test_halt(input logic [3:0] svc);
    send_instr(trap_instr(5'd0, 5'd0, svc), 32'h0);
    repeat (4) send_instr($urandom, $urandom);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_off_cycles = 300;
    run_random(20);
  endtask

  task automatic test_random_phases();
    send_idle_pct = 0;  recv_stall_pct = 0;  run_random(180);
    send_idle_pct = 88; recv_stall_pct = 0;  run_random(150);
    wait_drained();
    send_idle_pct = 0;  recv_stall_pct = 88; run_random(150);
    send_idle_pct = 10; recv_stall_pct = 10; run_random(180);
    send_idle_pct = 0;  recv_stall_pct = 0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.instr_word = 32'h0;
    in_ch.console_value = 32'h0;
    cfg.valid = 1'b0;
    cfg.reset_pc = 32'h0;
    out_ch.ready = 1'b0;
    reset_core_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_divide_overflow();
    wait_drained();
    write_start_pc(32'hffff_fffc);
    test_random_phases();
    test_backpressure();
    wait_drained();
    write_start_pc(32'h0040_0000);
    test_halt(4'ha);
    wait_drained();
    write_start_pc(32'h0);
    run_random(40);
    test_halt(4'hf);
    wait_drained();

    if (error_count == 0) begin
      $display("mips_subset_instruction_core_unit test passed");
    end else begin
      $display("mips_subset_instruction_core_unit test failed");
    end
    $finish;
  end

endmodule
